// ===== rtl/dmd_pkg.sv =====
// Shared widths, constants and coefficient tables for the deuteron momentum density block.
// Used by the stream interfaces, the pipelined divider and the top level; depends on nothing.
package dmd_pkg;

    // Field widths of the input and result words.
    localparam int MOM_W     = 17;
    localparam int DENS_W    = 32;

    // Internal widths.
    localparam int NUM_TERMS = 13;
    localparam int DEN_W     = 41;   // x + m_j^2 in Q32
    localparam int COEF_W    = 41;   // coefficient magnitude in Q24
    localparam int N_SHIFT   = 40;   // numerator is coefficient * 2^40
    localparam int QUO_W     = 54;   // quotient bits before rounding
    localparam int TERM_W    = QUO_W + 1;
    localparam int SUM_W     = 60;
    localparam int MAG_W     = 31;
    localparam int PX_W      = 55;
    localparam int PP_W      = 2 * MOM_W;
    localparam int KX_W      = 21;
    localparam int G_W       = 23;
    localparam int PG_W      = PP_W + G_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int S2_W      = SQ_W + 1;
    localparam int HI_W      = PG_W;

    // Adder tree sizes.
    localparam int L1_N      = (NUM_TERMS + 1) / 2;
    localparam int L2_N      = (L1_N + 1) / 2;
    localparam int L3_N      = (L2_N + 1) / 2;

    // Pipeline depth: 5 front stages, divider, 4 tree levels, 7 back stages.
    localparam int DIV_LAT   = QUO_W + 1;
    localparam int LAT       = 5 + DIV_LAT + 4 + 7;
    localparam int P_DLY     = 64;

    localparam logic [KX_W-1:0]  KX_Q16  = 21'd1683061;
    localparam logic [G_W-1:0]   G_Q16   = 23'd5429876;
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    localparam longint unsigned SCALE_E9  = 64'd1000000000;
    localparam longint unsigned SCALE_E16 = 64'd10000000000000000;
    localparam longint unsigned ALPHA_E8  = 64'd23162461;
    localparam longint unsigned STEP_E8   = 64'd100000000;

    // S-wave and D-wave coefficients in units of 1e-9.
    localparam longint S_COEF [NUM_TERMS] = '{
        64'sd886880760, -64'sd347170930, -64'sd3050238000, 64'sd56207766000,
        -64'sd749573340000, 64'sd5336527900000, -64'sd22706863000000,
        64'sd60434469000000, -64'sd102920580000000, 64'sd112233570000000,
        -64'sd75925226000000, 64'sd29059715000000, -64'sd4815736797830
    };

    localparam longint D_COEF [NUM_TERMS] = '{
        64'sd23135193, -64'sd856045720, 64'sd5606819300, -64'sd69462922000,
        64'sd416311180000, -64'sd1254662100000, 64'sd1238783000000,
        64'sd3373917200000, -64'sd13041151000000, 64'sd19512524000000,
        -64'sd15634324200000, 64'sd6623109600000, -64'sd1169818666773
    };

    // Coefficient magnitude rounded half up to Q24, evaluated at elaboration.
    function automatic logic [COEF_W-1:0] coef_q24(longint c);
        longint unsigned mag;
        longint unsigned q;
        longint unsigned r;
        mag = (c < 0) ? longint'(-c) : longint'(c);
        q = mag / SCALE_E9;
        r = mag % SCALE_E9;
        for (int i = 0; i < 24; i++)
        begin
            q = q << 1;
            r = r << 1;
            if (r >= SCALE_E9)
            begin
                r = r - SCALE_E9;
                q = q | 64'd1;
            end
        end
        if (r >= SCALE_E9 - r)
            q = q + 64'd1;
        return q[COEF_W-1:0];
    endfunction

    // Square of m_j = 0.23162461 + j, rounded half up to Q32.
    function automatic logic [DEN_W-1:0] m2_q32(int j);
        longint unsigned m;
        longint unsigned q;
        longint unsigned r;
        m = ALPHA_E8 + longint'(j) * STEP_E8;
        q = (m * m) / SCALE_E16;
        r = (m * m) % SCALE_E16;
        for (int i = 0; i < 32; i++)
        begin
            q = q << 1;
            r = r << 1;
            if (r >= SCALE_E16)
            begin
                r = r - SCALE_E16;
                q = q | 64'd1;
            end
        end
        if (r >= SCALE_E16 - r)
            q = q + 64'd1;
        return q[DEN_W-1:0];
    endfunction

endpackage

// ===== rtl/dmd_if.sv =====
// Stream interfaces for the momentum words going in and the density words coming out.
// Depends on dmd_pkg for the field widths.
interface dmd_mom_if;
    import dmd_pkg::*;
    logic             valid;
    logic             ready;
    logic [MOM_W-1:0] momentum;

    modport source (output valid, output momentum, input ready);
    modport sink (input valid, input momentum, output ready);
endinterface

interface dmd_dens_if;
    import dmd_pkg::*;
    logic              valid;
    logic              ready;
    logic [DENS_W-1:0] density;

    modport source (output valid, output density, input ready);
    modport sink (input valid, input density, output ready);
endinterface

// ===== rtl/deuteron_momentum_density.sv =====
// Top level of the deuteron momentum density pipeline.
// Depends on dmd_pkg, the stream interfaces in dmd_if and dmd_div_pipe.
//
//  channel | dir | word                  | handshake
//  --------+-----+-----------------------+-------------------
//  req     | in  | momentum, Q1.16 GeV/c | valid / ready
//  rsp     | out | density, Q8.24        | valid / ready
//
// One word is taken every cycle while no finished density waits untaken.
// Depth is set by the 54-step restoring dividers, one per term and wave.
// Reset clears only the valid bits of the pipeline.
// While a finished density waits untaken, the whole pipeline holds and req.ready is low.
module deuteron_momentum_density
    import dmd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    dmd_mom_if.sink            req,
    dmd_dens_if.source         rsp
);

    logic                     en;
    logic [LAT-1:0]           vld_reg;

    logic [MOM_W-1:0]         p_reg;
    logic [PP_W-1:0]          p2_reg;
    logic [PX_W-1:0]          px_reg;
    logic [DEN_W-1:0]         x_reg;
    logic [DEN_W-1:0]         den_reg [NUM_TERMS];
    logic [TERM_W-1:0]        term_s [NUM_TERMS];
    logic [TERM_W-1:0]        term_d [NUM_TERMS];

    logic signed [SUM_W-1:0]  lv0 [2][NUM_TERMS];
    logic signed [SUM_W-1:0]  lv1_reg [2][L1_N];
    logic signed [SUM_W-1:0]  lv2_reg [2][L2_N];
    logic signed [SUM_W-1:0]  lv3_reg [2][L3_N];
    logic signed [SUM_W-1:0]  sum_reg [2];

    logic [SUM_W-1:0]         mag_abs [2];
    logic [SUM_W-1:0]         mag_rnd [2];
    logic [MAG_W-1:0]         mag_reg [2];
    logic [SQ_W-1:0]          sq_reg [2];
    logic [S2_W-1:0]          s2_reg;

    logic [MOM_W-1:0]         p_line_reg [P_DLY];
    logic [PP_W-1:0]          pp_reg;
    logic [PG_W-1:0]          pg_reg;

    logic [63:0]              p00_reg;
    logic [62:0]              p01_reg;
    logic [56:0]              p10_reg;
    logic [55:0]              p11_reg;
    logic [63:0]              p00_d_reg;
    logic [63:0]              mid_reg;
    logic [55:0]              p11_d_reg;
    logic [HI_W-1:0]          hi_reg;
    logic [120:0]             total;
    logic [HI_W-1:0]          hi_rnd;
    logic [DENS_W-1:0]        res_reg;

    // The pipeline advances unless the result word is held by the sink.
    assign en        = !vld_reg[LAT-1] || rsp.ready;
    assign req.ready = en;
    assign rsp.valid = vld_reg[LAT-1];
    assign rsp.density = res_reg;

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], req.valid};
        end
    end

    // Front: momentum squared, scaled to inverse fermi squared, rounded to Q32.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= req.momentum;
            p2_reg <= PP_W'(p_reg) * PP_W'(p_reg);
            px_reg <= PX_W'(p2_reg) * PX_W'(KX_Q16);
            x_reg  <= DEN_W'((px_reg + PX_W'(32768)) >> 16);
        end
    end

    // One denominator per term, shared by the S and D dividers.
    for (genvar j = 0; j < NUM_TERMS; j++)
    begin : g_term
        localparam logic [DEN_W-1:0]  M2    = m2_q32(j);
        localparam logic [COEF_W-1:0] CS    = coef_q24(S_COEF[j]);
        localparam logic [COEF_W-1:0] CD    = coef_q24(D_COEF[j]);
        localparam bit                S_NEG = S_COEF[j] < 0;
        localparam bit                D_NEG = D_COEF[j] < 0;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[j] <= x_reg + M2;
            end
        end

        dmd_div_pipe u_div_s
        (
            .clk   (clk),
            .en    (en),
            .numer (CS),
            .den   (den_reg[j]),
            .quo   (term_s[j])
        );

        dmd_div_pipe u_div_d
        (
            .clk   (clk),
            .en    (en),
            .numer (CD),
            .den   (den_reg[j]),
            .quo   (term_d[j])
        );

        // Apply the coefficient sign.
        assign lv0[0][j] = S_NEG ? -$signed(SUM_W'(term_s[j])) : $signed(SUM_W'(term_s[j]));
        assign lv0[1][j] = D_NEG ? -$signed(SUM_W'(term_d[j])) : $signed(SUM_W'(term_d[j]));
    end

    // Registered adder trees for the two wave sums.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int w = 0; w < 2; w++)
            begin
                for (int i = 0; i < L1_N; i++)
                begin
                    if (2 * i + 1 < NUM_TERMS)
                        lv1_reg[w][i] <= lv0[w][2*i] + lv0[w][2*i+1];
                    else
                        lv1_reg[w][i] <= lv0[w][2*i];
                end
                for (int i = 0; i < L2_N; i++)
                begin
                    if (2 * i + 1 < L1_N)
                        lv2_reg[w][i] <= lv1_reg[w][2*i] + lv1_reg[w][2*i+1];
                    else
                        lv2_reg[w][i] <= lv1_reg[w][2*i];
                end
                for (int i = 0; i < L3_N; i++)
                begin
                    if (2 * i + 1 < L2_N)
                        lv3_reg[w][i] <= lv2_reg[w][2*i] + lv2_reg[w][2*i+1];
                    else
                        lv3_reg[w][i] <= lv2_reg[w][2*i];
                end
                sum_reg[w] <= lv3_reg[w][0] + lv3_reg[w][1];
            end
        end
    end

    // Magnitudes rounded to Q24 and saturated.
    always_comb
    begin
        for (int w = 0; w < 2; w++)
        begin
            mag_abs[w] = sum_reg[w][SUM_W-1] ? SUM_W'(-sum_reg[w]) : SUM_W'(sum_reg[w]);
            mag_rnd[w] = (mag_abs[w] + SUM_W'(128)) >> 8;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int w = 0; w < 2; w++)
            begin
                mag_reg[w] <= (mag_rnd[w] > SUM_W'(MAG_MAX)) ? MAG_MAX
                                                             : mag_rnd[w][MAG_W-1:0];
                sq_reg[w]  <= SQ_W'(mag_reg[w]) * SQ_W'(mag_reg[w]);
            end
            s2_reg <= S2_W'(sq_reg[0]) + S2_W'(sq_reg[1]);
        end
    end

    // Momentum delay line up to the final scaling, then p^2 * G.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_line_reg[0] <= p_reg;
            for (int i = 1; i < P_DLY; i++)
            begin
                p_line_reg[i] <= p_line_reg[i-1];
            end
            pp_reg <= PP_W'(p_line_reg[P_DLY-1]) * PP_W'(p_line_reg[P_DLY-1]);
            pg_reg <= PG_W'(pp_reg) * PG_W'(G_Q16);
        end
    end

    // High word of pg * s2 from four partial products.
    assign total  = 121'(p00_d_reg) + (121'(mid_reg) << 32) + (121'(p11_d_reg) << 64);
    assign hi_rnd = hi_reg + HI_W'(128);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg   <= 64'(pg_reg[31:0]) * 64'(s2_reg[31:0]);
            p01_reg   <= 63'(pg_reg[31:0]) * 63'(s2_reg[S2_W-1:32]);
            p10_reg   <= 57'(pg_reg[PG_W-1:32]) * 57'(s2_reg[31:0]);
            p11_reg   <= 56'(pg_reg[PG_W-1:32]) * 56'(s2_reg[S2_W-1:32]);
            mid_reg   <= 64'(p01_reg) + 64'(p10_reg);
            p00_d_reg <= p00_reg;
            p11_d_reg <= p11_reg;
            hi_reg    <= total[120:64];
            res_reg   <= (hi_rnd[HI_W-1:8] > (HI_W-8)'({DENS_W{1'b1}})) ? {DENS_W{1'b1}}
                                                                        : hi_rnd[DENS_W+7:8];
        end
    end

    // A held result word must keep the input side closed.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("input accepted while result word is stalled");

    // A stall freezes every valid bit in the pipeline.
    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

endmodule

// ===== rtl/dmd_div_pipe.sv =====
// Pipelined restoring divider: round(numer * 2^40 / den), one quotient bit per stage.
// Depends on dmd_pkg for the widths; advances only when en is high.
module dmd_div_pipe
    import dmd_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [COEF_W-1:0] numer,
    input  logic [DEN_W-1:0]  den,
    output logic [TERM_W-1:0] quo
);

    logic [DEN_W-1:0]  rem_reg [QUO_W];
    logic [DEN_W-1:0]  dvs_reg [QUO_W];
    logic [QUO_W-1:0]  quo_reg [QUO_W];
    logic [TERM_W-1:0] res_reg;
    logic              round_up;

    // One quotient bit per stage; the divisor travels with the partial remainder.
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        localparam int BIT_IDX = QUO_W - 1 - k;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] dvs_in;
        logic [QUO_W-1:0] q_in;
        logic             nbit;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            // The quotient fits in QUO_W bits, so the top numerator bits are below den.
            assign rem_in = DEN_W'(numer >> (QUO_W - N_SHIFT));
            assign dvs_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign q_in   = quo_reg[k-1];
        end

        if (BIT_IDX >= N_SHIFT)
        begin : g_nbit
            assign nbit = numer[BIT_IDX-N_SHIFT];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        assign trial = {rem_in, nbit};
        assign diff  = trial - {1'b0, dvs_in};
        assign ge    = trial >= {1'b0, dvs_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                dvs_reg[k] <= dvs_in;
                quo_reg[k] <= {q_in[QUO_W-2:0], ge};
            end
        end
    end

    // Round half up: bump when twice the remainder reaches the divisor.
    assign round_up = {rem_reg[QUO_W-1], 1'b0} >= {1'b0, dvs_reg[QUO_W-1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= TERM_W'(quo_reg[QUO_W-1]) + TERM_W'(round_up);
        end
    end

    assign quo = res_reg;

endmodule
